// ===== src/rbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfe_pkg
// Shared types and codes for the ring buffer frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package rbfe_pkg;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVWR    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_CSUM    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_CAPACITY   = 3'd0,
    REG_HDR_BYTES  = 3'd1,
    REG_HDR_LEN    = 3'd2,
    REG_ELEM_WIDTH = 3'd3,
    REG_BYTE_ORDER = 3'd4,
    REG_ELEM_COUNT = 3'd5,
    REG_CHECK_EN   = 3'd6
  } reg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POP  = 8'b0000_0010,
    S_SRCH = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_ASM  = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_NOFR = 8'b1000_0000
  } state_t;

  // Header byte k of the pattern; bytes past the fourth read as zero.
  function automatic logic [7:0] hdr_byte(input logic [31:0] hdr, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = hdr[7:0];
      3'd1:    b = hdr[15:8];
      3'd2:    b = hdr[23:16];
      3'd3:    b = hdr[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/ring_buffer_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_frame_extractor
// Byte ring buffer with push, pop and header-synchronized frame extraction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | slave     | tvalid / tready  | tuser = op, tdata = byte_in
//  out_    | master    | tvalid / tready  | tdata = status,value,fill_level; tlast
//  cfg_    | write     | cfg_wr_en        | cfg_addr = register, cfg_wdata
//
//  Push and unused op are handled in the idle state. Pop does one ring memory
//  read. Extract: a header search compares one byte per read of the ring
//  memory read port; then, when checking is on, a checksum pass reads the
//  data bytes and the checksum byte; an assembly pass reads the data bytes
//  again and hands each element to the output. Reset (synchronous, rst_n low)
//  clears indices, fill level and output valid and sets the registers to
//  their defaults; the ring memory itself is not cleared, no pass is needed.
//  A stalled output holds the block: the next item is taken only when the
//  output register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_frame_extractor
  import rbfe_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int MAX_HEADER = 4,
  parameter int MAX_ELEMS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [2:0] status, [66:3] value, [74:67] fill_level
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // configuration registers
  logic [7:0]  cap_r;
  logic [31:0] hdr_r;
  logic [2:0]  hlen_r;
  logic [1:0]  wcode_r;
  logic        order_r;
  logic [5:0]  ecnt_r;
  logic        chk_r;

  // ring state
  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    rd_data_r;
  logic [IW-1:0] wi_r, wi_nxt, ri_r, ri_nxt;
  logic [7:0]    fill_r, fill_nxt;
  logic          wr_en;

  // sequencer state
  state_t      st_r, st_nxt;
  logic        ph_r, ph_nxt;
  logic [7:0]  i_r, i_nxt, pos_r, pos_nxt, sum_r, sum_nxt;
  logic [2:0]  j_r, j_nxt, b_r, b_nxt;
  logic [9:0]  k_r, k_nxt;
  logic [6:0]  e_r, e_nxt;
  logic        bad_r, bad_nxt;
  logic [63:0] v_r, v_nxt;
  logic [10:0] need_r, need_nxt;

  // output register
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [63:0] oval_r, oval_nxt;
  logic [7:0]  ofill_r, ofill_nxt;

  // effective configuration
  logic [8:0]  cap_eff;
  logic [2:0]  hl;
  logic [6:0]  ne;
  logic [9:0]  dlen;
  logic [2:0]  nb_m1;
  logic [7:0]  hsum;
  logic [10:0] off_c, addr_sum, need_c;
  logic [IW-1:0] addr_c;
  logic        slot_free, accept;
  logic [63:0] v_base, v_asm;

  always_comb begin
    if (cap_r == 8'd0) begin
      cap_eff = 9'd1;
    end else if ({1'b0, cap_r} > 9'(RING_DEPTH)) begin
      cap_eff = 9'(RING_DEPTH);
    end else begin
      cap_eff = {1'b0, cap_r};
    end
    if (hlen_r == 3'd0) begin
      hl = 3'd1;
    end else if ({1'b0, hlen_r} > 4'(MAX_HEADER)) begin
      hl = 3'(MAX_HEADER);
    end else begin
      hl = hlen_r;
    end
    if (ecnt_r == 6'd0) begin
      ne = 7'd1;
    end else if ({1'b0, ecnt_r} > 7'(MAX_ELEMS)) begin
      ne = 7'(MAX_ELEMS);
    end else begin
      ne = {1'b0, ecnt_r};
    end
    dlen  = 10'(ne) << wcode_r;
    nb_m1 = 3'((4'd1 << wcode_r) - 4'd1);
    hsum  = 8'd0;
    for (int n = 0; n < 4; n++) begin
      if (3'(n) < hl) hsum = hsum + hdr_byte(hdr_r, 3'(n));
    end
  end

  // ring offset from the read side for the byte being looked at
  always_comb begin
    unique case (st_r)
      S_SRCH:        off_c = 11'(i_r) + 11'(j_r);
      S_SUM, S_ASM:  off_c = 11'(pos_r) + 11'(k_r);
      S_CHK:         off_c = 11'(pos_r) + 11'(dlen);
      default:       off_c = 11'd0;
    endcase
    addr_sum = 11'(ri_r) + off_c;
    if (addr_sum >= 11'(cap_eff)) addr_sum = addr_sum - 11'(cap_eff);
    addr_c = addr_sum[IW-1:0];
    need_c = 11'(i_r) + 11'(hl) + 11'(dlen) + 11'(chk_r);
  end

  // element assembly from the byte just read
  always_comb begin
    v_base = (b_r == 3'd0) ? 64'd0 : v_r;
    if (order_r) begin
      v_asm = v_base | (64'(rd_data_r) << {b_r, 3'b000});
    end else begin
      v_asm = {v_base[55:0], rd_data_r};
    end
  end

  assign slot_free = !ov_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ~ph_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    sum_nxt   = sum_r;
    bad_nxt   = bad_r;
    v_nxt     = v_r;
    need_nxt  = need_r;
    wi_nxt    = wi_r;
    ri_nxt    = ri_r;
    fill_nxt  = fill_r;
    wr_en     = 1'b0;
    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    ofill_nxt = ofill_r;

    unique case (st_r)
      S_IDLE: begin
        ph_nxt = 1'b0;
        i_nxt  = 8'd0;
        j_nxt  = 3'd0;
        if (accept) begin
          case (op_t'(in_tuser))
            OP_PUSH: begin
              wr_en     = 1'b1;
              wi_nxt    = (9'(wi_r) + 9'd1 >= cap_eff) ? '0 : IW'(9'(wi_r) + 9'd1);
              ov_nxt    = 1'b1;
              oval_nxt  = 64'd0;
              olast_nxt = 1'b1;
              if (9'(fill_r) >= cap_eff) begin
                ri_nxt    = (9'(ri_r) + 9'd1 >= cap_eff) ? '0 : IW'(9'(ri_r) + 9'd1);
                fill_nxt  = cap_eff[7:0];
                ost_nxt   = ST_OVWR;
                ofill_nxt = cap_eff[7:0];
              end else begin
                fill_nxt  = fill_r + 8'd1;
                ost_nxt   = ST_OK;
                ofill_nxt = fill_r + 8'd1;
              end
            end
            OP_POP: begin
              if (fill_r == 8'd0) begin
                ov_nxt    = 1'b1;
                ost_nxt   = ST_EMPTY;
                oval_nxt  = 64'd0;
                olast_nxt = 1'b1;
                ofill_nxt = fill_r;
              end else begin
                st_nxt = S_POP;
              end
            end
            OP_EXTRACT: st_nxt = S_SRCH;
            default: ;
          endcase
        end
      end

      S_POP: begin
        // hold until the read data of the oldest byte is back
        if (ph_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          oval_nxt  = 64'(rd_data_r);
          olast_nxt = 1'b1;
          ofill_nxt = fill_r - 8'd1;
          fill_nxt  = fill_r - 8'd1;
          ri_nxt    = (9'(ri_r) + 9'd1 >= cap_eff) ? '0 : IW'(9'(ri_r) + 9'd1);
          st_nxt    = S_IDLE;
        end
      end

      S_SRCH: begin
        if (!ph_r && j_r == 3'd0 && (9'(i_r) + 9'(hl) > 9'(fill_r))) begin
          st_nxt = S_NOFR;
        end else if (ph_r) begin
          if (rd_data_r != hdr_byte(hdr_r, j_r)) begin
            i_nxt = i_r + 8'd1;
            j_nxt = 3'd0;
          end else if (j_r == hl - 3'd1) begin
            // header matched; make sure the frame is wholly stored
            pos_nxt  = i_r + 8'(hl);
            need_nxt = need_c;
            k_nxt    = 10'd0;
            b_nxt    = 3'd0;
            e_nxt    = 7'd0;
            sum_nxt  = 8'd0;
            bad_nxt  = 1'b0;
            if (need_c > 11'(fill_r)) begin
              st_nxt = S_NOFR;
            end else if (chk_r) begin
              st_nxt = S_SUM;
            end else begin
              st_nxt = S_ASM;
            end
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end

      S_SUM: begin
        if (ph_r) begin
          sum_nxt = sum_r + rd_data_r;
          if (k_r == dlen - 10'd1) begin
            k_nxt  = 10'd0;
            st_nxt = S_CHK;
          end else begin
            k_nxt = k_r + 10'd1;
          end
        end
      end

      S_CHK: begin
        if (ph_r) begin
          bad_nxt = (rd_data_r != sum_r + hsum);
          st_nxt  = S_ASM;
        end
      end

      S_ASM: begin
        if (ph_r) begin
          v_nxt = v_asm;
          k_nxt = k_r + 10'd1;
          if (b_r == nb_m1) begin
            b_nxt  = 3'd0;
            st_nxt = S_EMIT;
          end else begin
            b_nxt = b_r + 3'd1;
          end
        end
      end

      S_EMIT: begin
        ph_nxt = 1'b0;
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = bad_r ? ST_CSUM : ST_OK;
          oval_nxt  = v_r;
          olast_nxt = (e_r == ne - 7'd1);
          ofill_nxt = fill_r - need_r[7:0];
          e_nxt     = e_r + 7'd1;
          if (e_r == ne - 7'd1) begin
            // drop the whole frame from the read side
            fill_nxt = fill_r - need_r[7:0];
            ri_nxt   = (11'(ri_r) + need_r >= 11'(cap_eff)) ?
                       IW'(11'(ri_r) + need_r - 11'(cap_eff)) : IW'(11'(ri_r) + need_r);
            st_nxt   = S_IDLE;
          end else begin
            st_nxt = S_ASM;
          end
        end
      end

      S_NOFR: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_NOFRAME;
          oval_nxt  = 64'd0;
          olast_nxt = 1'b1;
          ofill_nxt = fill_r;
          st_nxt    = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    // capacity write sets the ring up afresh
    if (cfg_wr_en && cfg_addr == REG_CAPACITY) begin
      wi_nxt   = '0;
      ri_nxt   = '0;
      fill_nxt = 8'd0;
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wi_r] <= in_tdata;
    rd_data_r <= mem[addr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ph_r    <= 1'b0;
      wi_r    <= '0;
      ri_r    <= '0;
      fill_r  <= 8'd0;
      ov_r    <= 1'b0;
      cap_r   <= 8'd255;
      hdr_r   <= 32'd0;
      hlen_r  <= 3'd1;
      wcode_r <= 2'd0;
      order_r <= 1'b1;
      ecnt_r  <= 6'd1;
      chk_r   <= 1'b1;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      wi_r   <= wi_nxt;
      ri_r   <= ri_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_CAPACITY:   cap_r   <= cfg_wdata[7:0];
          REG_HDR_BYTES:  hdr_r   <= cfg_wdata;
          REG_HDR_LEN:    hlen_r  <= cfg_wdata[2:0];
          REG_ELEM_WIDTH: wcode_r <= cfg_wdata[1:0];
          REG_BYTE_ORDER: order_r <= cfg_wdata[0];
          REG_ELEM_COUNT: ecnt_r  <= cfg_wdata[5:0];
          REG_CHECK_EN:   chk_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    sum_r   <= sum_nxt;
    bad_r   <= bad_nxt;
    v_r     <= v_nxt;
    need_r  <= need_nxt;
    ost_r   <= ost_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    ofill_r <= ofill_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, ofill_r, oval_r, ost_r};

  // fill level never exceeds the effective capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    9'(fill_r) <= cap_eff)
    else $error("fill level above capacity");

  // both indices stay inside the ring
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (9'(wi_r) < cap_eff) && (9'(ri_r) < cap_eff))
    else $error("ring index out of range");

  // a busy sequencer takes no new transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");

  // a frame is dropped only after its final element is handed over
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && st_nxt == S_IDLE) |-> (ov_nxt && olast_nxt))
    else $error("frame dropped without final element");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring buffer frame extractor. Pushes, pops and
// frame extracts are driven over the input stream under several register
// settings; a scoreboard predicts every result transaction and compares it
// field by field with what the block emits, with random stalls on both sides.
// ----------------------------------------------------------------------------

import rbfe_pkg::*;

typedef struct {
  status_t     status;
  logic [63:0] value;
  logic        last;
  logic [7:0]  fill;
} ring_result_t;

class ring_scoreboard;
  logic [7:0]   ring [256];
  int unsigned  wr_idx, rd_idx, fill;
  int unsigned  cap_reg, hl_reg, wcode_reg, order_reg, ne_reg, check_reg;
  logic [31:0]  hdr_reg;
  ring_result_t pending_q[$];
  int           errors;

  function new();
    cap_reg = 255; hdr_reg = 0; hl_reg = 1; wcode_reg = 0;
    order_reg = 1; ne_reg = 1; check_reg = 1;
    wr_idx = 0; rd_idx = 0; fill = 0; errors = 0;
  endfunction

  function int unsigned eff_cap();
    return (cap_reg == 0) ? 1 : cap_reg;
  endfunction

  function logic [7:0] peek(int unsigned k);
    return ring[(rd_idx + k) % eff_cap()];
  endfunction

  function logic [7:0] take();
    logic [7:0] b;
    b = peek(0);
    rd_idx = (rd_idx + 1) % eff_cap();
    if (fill > 0) fill--;
    return b;
  endfunction

  function void write_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_CAPACITY: begin
        cap_reg = v[7:0]; wr_idx = 0; rd_idx = 0; fill = 0;
      end
      REG_HDR_BYTES:  hdr_reg = v;
      REG_HDR_LEN:    hl_reg = v[2:0];
      REG_ELEM_WIDTH: wcode_reg = v[1:0];
      REG_BYTE_ORDER: order_reg = v[0];
      REG_ELEM_COUNT: ne_reg = v[5:0];
      REG_CHECK_EN:   check_reg = v[0];
      default: ;
    endcase
  endfunction

  function void add(status_t st, logic [63:0] v, logic lst);
    ring_result_t r;
    r.status = st; r.value = v; r.last = lst; r.fill = 0;
    pending_q.push_back(r);
  endfunction

  // Predict the result transactions caused by one accepted input.
  function void note_input(op_t op, logic [7:0] b);
    int unsigned  n0, hl, ne, nb, pos, need, i, j, e;
    bit           found;
    logic [7:0]   sum, x;
    logic [63:0]  v;
    logic [63:0]  vals [32];
    status_t      st;
    n0 = pending_q.size();
    case (op)
      OP_PUSH: begin
        ring[wr_idx] = b;
        wr_idx = (wr_idx + 1) % eff_cap();
        if (fill >= eff_cap()) begin
          rd_idx = (rd_idx + 1) % eff_cap();
          add(ST_OVWR, 0, 1);
        end else begin
          fill++;
          add(ST_OK, 0, 1);
        end
      end
      OP_POP: begin
        if (fill == 0) add(ST_EMPTY, 0, 1);
        else add(ST_OK, {56'd0, take()}, 1);
      end
      OP_EXTRACT: begin
        hl = (hl_reg == 0) ? 1 : (hl_reg > 4 ? 4 : hl_reg);
        ne = (ne_reg == 0) ? 1 : (ne_reg > 32 ? 32 : ne_reg);
        nb = 1 << wcode_reg;
        found = 0; pos = 0; sum = 0; st = ST_OK;
        for (i = 0; !found && i + hl <= fill; i++) begin
          for (j = 0; j < hl; j++)
            if (peek(i + j) != hdr_reg[8*j +: 8]) break;
          if (j == hl) begin
            found = 1; pos = i + hl;
          end
        end
        need = pos + ne * nb + check_reg;
        if (!found || need > fill) begin
          add(ST_NOFRAME, 0, 1);
        end else begin
          for (i = 0; i < pos; i++) x = take();
          for (e = 0; e < ne; e++) begin
            v = 0;
            for (j = 0; j < nb; j++) begin
              x = take();
              sum = sum + x;
              if (order_reg) v = v | (64'(x) << (8 * j));
              else v = (v << 8) | 64'(x);
            end
            vals[e] = v;
          end
          if (check_reg) begin
            for (j = 0; j < hl; j++) sum = sum + hdr_reg[8*j +: 8];
            if (take() != sum) st = ST_CSUM;
          end
          for (e = 0; e < ne; e++) add(st, vals[e], e + 1 == ne);
        end
      end
      default: ;
    endcase
    // fill level is reported after the whole item
    for (i = n0; i < pending_q.size(); i++) pending_q[i].fill = fill[7:0];
  endfunction

  function void check_result(logic [79:0] d, logic lst);
    ring_result_t r;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: tdata=%h last=%b", d, lst);
      return;
    end
    r = pending_q.pop_front();
    if (d[2:0] != r.status || d[66:3] != r.value || lst != r.last || d[74:67] != r.fill)
    begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp st=%0d val=%h last=%b fill=%0d, got st=%0d val=%h last=%b fill=%0d",
                 r.status, r.value, r.last, r.fill, d[2:0], d[66:3], lst, d[74:67]);
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;   // [7:0] byte_in
  logic [1:0]  in_tuser = 0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;      // [2:0] status, [66:3] value, [74:67] fill_level
  logic        out_tlast;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_addr = 0;
  logic [31:0] cfg_wdata = 0;

  ring_scoreboard sb = new();
  bit quiet = 0;   // suppress idling on both sides

  ring_buffer_frame_extractor u_top (.*);

  always #5 clk = ~clk;

  // Stall the result side at random, except in quiet stretches.
  always @(negedge clk) out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 30);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  // Offer one input transaction and hold it until accepted. Enter at negedge.
  task automatic send(op_t op, logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, b);
    @(negedge clk);
  endtask

  // Hold the input off until every predicted result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Push a header, data and, when checking is on, a checksum, corrupting it now and then.
  task automatic push_frame(output int cnt);
    int unsigned hl, ne, nb, k;
    logic [7:0]  sum, b;
    hl = (sb.hl_reg == 0) ? 1 : (sb.hl_reg > 4 ? 4 : sb.hl_reg);
    ne = (sb.ne_reg == 0) ? 1 : (sb.ne_reg > 32 ? 32 : sb.ne_reg);
    nb = 1 << sb.wcode_reg;
    sum = 0; cnt = 0;
    for (k = 0; k < hl; k++) begin
      b = sb.hdr_reg[8*k +: 8];
      sum = sum + b;
      send(OP_PUSH, b); cnt++;
    end
    for (k = 0; k < ne * nb; k++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send(OP_PUSH, b); cnt++;
    end
    if (sb.check_reg) begin
      if ($urandom_range(0, 99) < 20) sum = sum ^ 8'(1 << $urandom_range(0, 7));
      send(OP_PUSH, sum); cnt++;
    end
  endtask

  task automatic run_phase(logic [7:0] cap, logic [31:0] hdr, logic [2:0] hl,
                           logic [1:0] wc, logic bo, logic [5:0] ne, logic ck,
                           int n_items, bit pause_mid);
    int done, c, r;
    bit paused;
    drain();
    write_cfg(REG_CAPACITY, 32'(cap));
    write_cfg(REG_HDR_BYTES, hdr);
    write_cfg(REG_HDR_LEN, 32'(hl));
    write_cfg(REG_ELEM_WIDTH, 32'(wc));
    write_cfg(REG_BYTE_ORDER, 32'(bo));
    write_cfg(REG_ELEM_COUNT, 32'(ne));
    write_cfg(REG_CHECK_EN, 32'(ck));
    done = 0; paused = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_frame(c);
        done += c;
        if ($urandom_range(0, 3) != 0) begin
          send(OP_EXTRACT, 8'($urandom_range(0, 255))); done++;
        end
      end else if (r < 72) begin
        send(OP_PUSH, 8'($urandom_range(0, 255))); done++;
      end else if (r < 82) begin
        send(OP_POP, 8'($urandom_range(0, 255))); done++;
      end else if (r < 86) begin
        send(OP_NONE, 8'($urandom_range(0, 255)));
      end else begin
        send(OP_EXTRACT, 8'($urandom_range(0, 255))); done++;
      end
      if (pause_mid && !paused && done > n_items / 2) begin
        drain();
        paused = 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty ring, unused op, byte extremes, short, good and bad-checksum frames, missing header.
    send(OP_POP, 8'hFF);
    send(OP_EXTRACT, 8'h00);
    send(OP_NONE, 8'hAA);
    send(OP_PUSH, 8'h00);
    send(OP_PUSH, 8'hFF);
    send(OP_EXTRACT, 8'h00);     // too short for data plus checksum
    send(OP_PUSH, 8'hFF);        // checksum = FF + header 00
    send(OP_EXTRACT, 8'h00);
    send(OP_PUSH, 8'h00);
    send(OP_PUSH, 8'h10);
    send(OP_PUSH, 8'h11);        // bad checksum
    send(OP_EXTRACT, 8'h00);
    send(OP_PUSH, 8'h5A);
    send(OP_EXTRACT, 8'h00);     // header missing
    send(OP_POP, 8'h00);
    send(OP_POP, 8'h00);         // now empty

    run_phase(8'd5,   32'h000000A5, 3'd1, 2'd0, 1'b1, 6'd2,  1'b1, 20, 0);
    quiet = 1;
    run_phase(8'd255, 32'h55AA33CC, 3'd4, 2'd3, 1'b0, 6'd3,  1'b1, 20, 0);
    quiet = 0;
    run_phase(8'd40,  32'hFFFFFFFF, 3'd2, 2'd1, 1'b0, 6'd4,  1'b0, 20, 1);
    run_phase(8'd0,   32'h00000012, 3'd0, 2'd0, 1'b0, 6'd0,  1'b1, 15, 0);
    run_phase(8'd255, 32'h00C0FFEE, 3'd7, 2'd2, 1'b1, 6'd4,  1'b0, 20, 0);
    run_phase(8'd60,  32'h0000BEEF, 3'd3, 2'd3, 1'b1, 6'd3,  1'b1, 20, 0);
    run_phase(8'd1,   32'h0000007E, 3'd1, 2'd0, 1'b1, 6'd1,  1'b0, 15, 0);
    run_phase(8'd255, 32'h00000081, 3'd1, 2'd0, 1'b0, 6'd40, 1'b1, 15, 0);

    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
